### design/option_symbol_field_parser_core_assert.svh
// ---------------------------------------------------------------------------
// option symbol field parser core assertion macros
// concurrent assertion wrappers, empty in synthesis builds
// ---------------------------------------------------------------------------
`ifndef OPTION_SYMBOL_FIELD_PARSER_CORE_ASSERT_SVH
`define OPTION_SYMBOL_FIELD_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define OSFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("osfp assertion failed");
`define OSFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("osfp assertion failed");
`else
`define OSFP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define OSFP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### design/osfp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// osfp_pkg
// shared constants, record types and helpers of the option symbol parser
// ---------------------------------------------------------------------------
package osfp_pkg;

	localparam int ROOT_CHARS    = 6;
	localparam int STRIKE_DIGITS = 8;
	localparam int EXPIRY_CHARS  = 6;
	localparam int TAIL_LEN      = EXPIRY_CHARS + 1 + STRIKE_DIGITS;
	localparam int LEN_MIN       = TAIL_LEN + 1;
	localparam int LEN_MAX       = TAIL_LEN + ROOT_CHARS;
	localparam int COUNT_SAT     = LEN_MAX + 1;
	localparam int CNT_W         = $clog2(COUNT_SAT + 1);
	localparam int SP_W          = 3;
	localparam int TEXT_W        = 48;
	localparam int RLEN_W        = 3;
	localparam int STRIKE_W      = 27;
	localparam int NPART         = (STRIKE_DIGITS + 1) / 2;

	localparam logic [SP_W-1:0] NO_SPACE   = 3'd7;
	localparam logic [7:0]      SPACE_CHAR = 8'h20;
	localparam logic [7:0]      ZERO_CHAR  = 8'h30;
	localparam logic [7:0]      NINE_CHAR  = 8'h39;

	typedef logic [7:0] char_t;

	typedef struct packed {
		logic                       len_ok;
		logic [CNT_W-1:0]           rlen;
		logic [ROOT_CHARS-1:0][7:0] head;
		logic [TAIL_LEN-1:0][7:0]   tail;
	} osfp_rec_t;

	typedef struct packed {
		logic                length_ok;
		logic [TEXT_W-1:0]   root_text;
		logic [RLEN_W-1:0]   root_length;
		logic [TEXT_W-1:0]   expiry_text;
		logic [7:0]          call_put;
		logic [STRIKE_W-1:0] strike_thousandths;
		logic                strike_error;
	} osfp_res_t;

	function automatic logic [STRIKE_W-1:0] pow10(input int k);
		logic [STRIKE_W-1:0] r;
		r = STRIKE_W'(1);
		for (int n = 0; n < k; n++) begin
			r = r * STRIKE_W'(10);
		end
		return r;
	endfunction

endpackage

### design/option_symbol_field_parser_core.sv
`timescale 1ns / 1ps
// path: a final character's record passes the queue, stage-one and result registers
// throughput: one character per cycle while full is low; the count and shift loop sets this
// results: at most one per symbol, one per cycle when pop stays high
// reset: arst_n clears the count, space mark, queue and pipeline valids; text stores need none
// ---------------------------------------------------------------------------
// option_symbol_field_parser_core
// option symbol parser: character intake, record queue, field evaluation
// ---------------------------------------------------------------------------
`include "option_symbol_field_parser_core_assert.svh"

module option_symbol_field_parser_core import osfp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [7:0]          ch,
	input  logic                last,
	output logic                empty,
	input  logic                pop,
	output logic                length_ok,
	output logic [TEXT_W-1:0]   root_text,
	output logic [RLEN_W-1:0]   root_length,
	output logic [TEXT_W-1:0]   expiry_text,
	output logic [7:0]          call_put,
	output logic [STRIKE_W-1:0] strike_thousandths,
	output logic                strike_error
);

	logic      q_full, rec_push, rec_valid, rec_ready;
	osfp_rec_t rec_in, rec_out;
	osfp_res_t res;

	osfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.ch       (ch),
		.last     (last),
		.q_full   (q_full),
		.rec_push (rec_push),
		.rec      (rec_in)
	);

	osfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_push   (rec_push),
		.in_rec    (rec_in),
		.q_full    (q_full),
		.out_valid (rec_valid),
		.out_ready (rec_ready),
		.out_rec   (rec_out)
	);

	osfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec       (rec_out),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign length_ok          = res.length_ok;
	assign root_text          = res.root_text;
	assign root_length        = res.root_length;
	assign expiry_text        = res.expiry_text;
	assign call_put           = res.call_put;
	assign strike_thousandths = res.strike_thousandths;
	assign strike_error       = res.strike_error;

	// a finished symbol always lands in the queue
	`OSFP_ASSERT_NEXT(a_last_queued, clk, arst_n, push && !full && last, rec_valid)
	// strike error only on a well-formed length
	`OSFP_ASSERT_SAME(a_err_len, clk, arst_n, !empty && strike_error, length_ok)
	// bad length gives an all-zero record
	`OSFP_ASSERT_SAME(a_bad_len_zero, clk, arst_n, !empty && !length_ok,
		root_text == '0 && root_length == '0 && expiry_text == '0 && call_put == '0
		&& strike_thousandths == '0 && !strike_error)

endmodule

### design/osfp_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// osfp_front
// character intake: length count, head and tail capture, record build
// ---------------------------------------------------------------------------
module osfp_front import osfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  char_t     ch,
	input  logic      last,
	input  logic      q_full,
	output logic      rec_push,
	output osfp_rec_t rec
);

	logic [CNT_W-1:0]           cnt_q, cnt_nx, base;
	logic [SP_W-1:0]            space_q, space_nx;
	logic [ROOT_CHARS-1:0][7:0] head_q, head_nx;
	logic [TAIL_LEN-1:0][7:0]   tail_q, tail_nx;
	logic                       acc;

	assign full     = q_full;
	assign acc      = push && !q_full;
	assign rec_push = acc && last;

	always_comb begin
		cnt_nx = (cnt_q < CNT_W'(COUNT_SAT)) ? cnt_q + CNT_W'(1) : cnt_q;
		space_nx = space_q;
		if (ch == SPACE_CHAR && space_q == NO_SPACE && cnt_q < CNT_W'(ROOT_CHARS)
				&& cnt_q < CNT_W'(NO_SPACE)) begin
			space_nx = SP_W'(cnt_q);
		end
		for (int i = 0; i < ROOT_CHARS; i++) begin
			head_nx[i] = (cnt_q == CNT_W'(i)) ? ch : head_q[i];
		end
		for (int i = 0; i < TAIL_LEN - 1; i++) begin
			tail_nx[i] = tail_q[i+1];
		end
		tail_nx[TAIL_LEN-1] = ch;
	end

	// classification of the finished symbol
	always_comb begin
		base       = cnt_nx - CNT_W'(TAIL_LEN);
		rec.len_ok = (cnt_nx >= CNT_W'(LEN_MIN)) && (cnt_nx <= CNT_W'(LEN_MAX));
		rec.rlen   = (CNT_W'(space_nx) < base) ? CNT_W'(space_nx) : base;
		rec.head   = head_nx;
		rec.tail   = tail_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			space_q <= NO_SPACE;
		end else if (acc) begin
			if (last) begin
				cnt_q   <= '0;
				space_q <= NO_SPACE;
			end else begin
				cnt_q   <= cnt_nx;
				space_q <= space_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			head_q <= head_nx;
			tail_q <= tail_nx;
		end
	end

endmodule

### design/osfp_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// osfp_queue
// two-entry record queue between intake and field evaluation
// ---------------------------------------------------------------------------
module osfp_queue import osfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_push,
	input  osfp_rec_t in_rec,
	output logic      q_full,
	output logic      out_valid,
	input  logic      out_ready,
	output osfp_rec_t out_rec
);

	logic [1:0] cnt_q;
	osfp_rec_t  head_q, next_q;
	logic       deq, to_head;

	assign q_full    = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_rec   = head_q;
	assign deq       = out_valid && out_ready;
	assign to_head   = in_push && (cnt_q == 2'd0 || (cnt_q == 2'd1 && deq));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 2'(in_push) - 2'(deq);
		end
	end

	always_ff @(posedge clk) begin
		if (to_head) begin
			head_q <= in_rec;
		end else if (deq) begin
			head_q <= next_q;
		end
		if (in_push && !to_head) begin
			next_q <= in_rec;
		end
	end

endmodule

### design/osfp_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// osfp_back
// field evaluation: root masking, strike conversion, result register
// ---------------------------------------------------------------------------
module osfp_back import osfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rec_valid,
	output logic      rec_ready,
	input  osfp_rec_t rec,
	output logic      empty,
	input  logic      pop,
	output osfp_res_t res
);

	logic                      v_s1, len_ok_s1, err_s1;
	logic [RLEN_W-1:0]         rlen_s1;
	logic [TEXT_W-1:0]         root_s1, exp_s1;
	logic [7:0]                cp_s1;
	logic [STRIKE_W-1:0]       part_s1 [NPART];
	logic                      out_v_q, adv, s1_en;
	osfp_res_t                 res_q, res_nx;

	logic [ROOT_CHARS*8-1:0]   root_full;
	logic [TEXT_W-1:0]         exp_c;
	logic                      err_c;
	logic [STRIKE_W-1:0]       term [STRIKE_DIGITS];
	logic [STRIKE_W-1:0]       part_c [NPART];
	logic [STRIKE_W-1:0]       dval, strike_sum;
	char_t                     dch;

	assign adv       = !out_v_q || pop;
	assign s1_en     = !v_s1 || adv;
	assign rec_ready = s1_en;
	assign empty     = !out_v_q;
	assign res       = res_q;

	// stage one: text fields, digit check, weighted digit pairs
	always_comb begin
		root_full = '0;
		for (int i = 0; i < ROOT_CHARS; i++) begin
			if (CNT_W'(i) < rec.rlen) begin
				root_full[(ROOT_CHARS-1-i)*8 +: 8] = rec.head[i];
			end
		end
		exp_c = '0;
		for (int i = 0; i < EXPIRY_CHARS; i++) begin
			exp_c[(EXPIRY_CHARS-1-i)*8 +: 8] = rec.tail[i];
		end
		err_c = 1'b0;
		for (int i = 0; i < STRIKE_DIGITS; i++) begin
			dch = rec.tail[EXPIRY_CHARS+1+i];
			if (dch < ZERO_CHAR || dch > NINE_CHAR) begin
				err_c = 1'b1;
			end
			dval    = STRIKE_W'(dch[3:0]);
			term[i] = dval * pow10(STRIKE_DIGITS - 1 - i);
		end
		for (int j = 0; j < NPART; j++) begin
			part_c[j] = term[2*j];
			if (2*j + 1 < STRIKE_DIGITS) begin
				part_c[j] = part_c[j] + term[2*j+1];
			end
		end
	end

	// stage two: final sum and zeroing
	always_comb begin
		strike_sum = '0;
		for (int j = 0; j < NPART; j++) begin
			strike_sum = strike_sum + part_s1[j];
		end
		res_nx = '0;
		if (len_ok_s1) begin
			res_nx.length_ok          = 1'b1;
			res_nx.root_text          = root_s1;
			res_nx.root_length        = rlen_s1;
			res_nx.expiry_text        = exp_s1;
			res_nx.call_put           = cp_s1;
			res_nx.strike_thousandths = err_s1 ? '0 : strike_sum;
			res_nx.strike_error       = err_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_en) begin
				v_s1 <= rec_valid;
			end
			if (adv) begin
				out_v_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en && rec_valid) begin
			len_ok_s1 <= rec.len_ok;
			rlen_s1   <= RLEN_W'(rec.rlen);
			root_s1   <= TEXT_W'(root_full);
			exp_s1    <= exp_c;
			cp_s1     <= rec.tail[EXPIRY_CHARS];
			err_s1    <= err_c;
			for (int j = 0; j < NPART; j++) begin
				part_s1[j] <= part_c[j];
			end
		end
		if (adv && v_s1) begin
			res_q <= res_nx;
		end
	end

endmodule
